// ----- src/vad_pkg.sv -----
// Shared constants and the arctangent table for the vector angle pipeline.
package vad_pkg;

    // Angle accumulator: signed, 2^-24 degree per LSB.
    localparam int ACC_FRAC  = 24;
    localparam int ACC_W     = 35;
    localparam int TABLE_LEN = 24;

    // Coordinates are scaled so that the difference lands at bit 60.
    localparam int SCALE_TOP = 60;
    localparam int XY_W      = SCALE_TOP + 3;

    localparam int HEADING_W = 16;

    localparam logic signed [ACC_W-1:0] DEG180 = ACC_W'(64'd180 << ACC_FRAC);
    localparam logic signed [ACC_W-1:0] DEG360 = ACC_W'(64'd360 << ACC_FRAC);

    // round(atan(2^-i) * 180/pi * 2^24)
    localparam logic [29:0] ATAN_TAB [TABLE_LEN] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    // Table entry for a stage; later stages reuse the last entry.
    function automatic logic signed [ACC_W-1:0] atan_step(input int unsigned i);
        int unsigned k;
        k = (i < TABLE_LEN) ? i : TABLE_LEN - 1;
        return signed'(ACC_W'(ATAN_TAB[k]));
    endfunction

endpackage

// ----- src/vad_if.sv -----
// Valid/ready channels for point pairs and headings.
interface vad_pt_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] from_x;
    logic signed [COORD_BITS-1:0] from_y;
    logic signed [COORD_BITS-1:0] to_x;
    logic signed [COORD_BITS-1:0] to_y;

    modport source (output valid, from_x, from_y, to_x, to_y, input ready);
    modport sink   (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

interface vad_hd_if;
    logic        valid;
    logic        ready;
    logic [15:0] heading;

    modport source (output valid, heading, input ready);
    modport sink   (input valid, heading, output ready);
endinterface

// ----- src/vad_prep.sv -----
// Front stage: point differences, scaling and half-plane fold.
module vad_prep
    import vad_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_from_x,
    input  logic signed [COORD_BITS-1:0] i_from_y,
    input  logic signed [COORD_BITS-1:0] i_to_x,
    input  logic signed [COORD_BITS-1:0] i_to_y,
    output logic signed [XY_W-1:0]       o_x,
    output logic signed [XY_W-1:0]       o_y,
    output logic signed [ACC_W-1:0]      o_acc,
    output logic                         o_zero
);
    localparam int PRESCALE = SCALE_TOP - COORD_BITS;
    localparam int D_W      = COORD_BITS + 1;

    logic signed [D_W-1:0]   w_dx, w_dy;
    logic signed [XY_W-1:0]  w_xs, w_ys;
    logic signed [XY_W-1:0]  n_x, n_y;
    logic signed [ACC_W-1:0] n_acc;
    logic                    n_zero;

    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_zero;

    always_comb begin
        w_dx = {i_to_x[COORD_BITS-1], i_to_x} - {i_from_x[COORD_BITS-1], i_from_x};
        w_dy = {i_to_y[COORD_BITS-1], i_to_y} - {i_from_y[COORD_BITS-1], i_from_y};
        w_xs = {{(XY_W-D_W){w_dx[D_W-1]}}, w_dx} <<< PRESCALE;
        w_ys = {{(XY_W-D_W){w_dy[D_W-1]}}, w_dy} <<< PRESCALE;
        n_zero = (w_dx == '0) && (w_dy == '0);
        // fold the left half-plane onto the right by a half turn
        if (w_dx[D_W-1]) begin
            n_x   = -w_xs;
            n_y   = -w_ys;
            n_acc = DEG180;
        end else begin
            n_x   = w_xs;
            n_y   = w_ys;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= n_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_zero = r_zero;
endmodule

// ----- src/vad_cordic_stage.sv -----
// One registered CORDIC vectoring micro-rotation.
module vad_cordic_stage
    import vad_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [XY_W-1:0]  i_x,
    input  logic signed [XY_W-1:0]  i_y,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic                    i_zero,
    output logic signed [XY_W-1:0]  o_x,
    output logic signed [XY_W-1:0]  o_y,
    output logic signed [ACC_W-1:0] o_acc,
    output logic                    o_zero
);
    localparam logic signed [ACC_W-1:0] ANG = atan_step(STAGE);

    logic signed [XY_W-1:0]  w_xs, w_ys;
    logic                    w_pos;
    logic signed [XY_W-1:0]  n_x, n_y;
    logic signed [ACC_W-1:0] n_acc;

    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_zero;

    always_comb begin
        w_xs  = i_x >>> STAGE;
        w_ys  = i_y >>> STAGE;
        w_pos = !i_y[XY_W-1] && (i_y != '0);
        // rotate towards the x axis, both updates from the old pair
        if (w_pos) begin
            n_x   = i_x + w_ys;
            n_y   = i_y - w_xs;
            n_acc = i_acc + ANG;
        end else begin
            n_x   = i_x - w_ys;
            n_y   = i_y + w_xs;
            n_acc = i_acc - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_acc  <= n_acc;
            r_zero <= i_zero;
        end
    end

    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_acc  = r_acc;
    assign o_zero = r_zero;
endmodule

// ----- src/vad_finish.sv -----
// Back stages: wrap into one turn, round to the output grid, output register.
module vad_finish
    import vad_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                    i_clk,
    input  logic                    i_en_round,
    input  logic                    i_en_out,
    input  logic signed [ACC_W-1:0] i_acc,
    input  logic                    i_zero,
    output logic [HEADING_W-1:0]    o_heading
);
    localparam int SH  = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int H_W = ACC_W - SH;
    localparam logic [ACC_W-1:0] HALF = ACC_W'(64'd1 << (SH - 1));
    localparam logic [H_W-1:0]   FULL = H_W'(64'd360 << ANGLE_FRAC_BITS);

    logic signed [ACC_W-1:0]     w_wrap;
    logic [ACC_W-1:0]            w_sum;
    logic [H_W-1:0]              w_h;
    logic [H_W+HEADING_W-1:0]    w_ext;

    logic [H_W-1:0]              r_h;
    logic                        r_zero;
    logic [HEADING_W-1:0]        r_heading;

    always_comb begin
        w_wrap = i_acc[ACC_W-1] ? i_acc + DEG360 : i_acc;
        if (w_wrap[ACC_W-1]) begin
            w_wrap = '0;
        end
        w_sum = $unsigned(w_wrap) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_round) begin
            r_h    <= w_sum[ACC_W-1:SH];
            r_zero <= i_zero;
        end
    end

    always_comb begin
        // a value rounded up to a full turn wraps to zero
        w_h   = (r_h >= FULL) ? r_h - FULL : r_h;
        if (r_zero) begin
            w_h = '0;
        end
        w_ext = {{HEADING_W{1'b0}}, w_h};
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            r_heading <= w_ext[HEADING_W-1:0];
        end
    end

    assign o_heading = r_heading;
endmodule

// ----- src/vector_angle_degrees.sv -----
// Top level: direction from point A to point B in 1/128 degree, pipelined CORDIC.
// Stages: one difference stage, one stage per micro-rotation, one rounding stage, one output stage.
// Throughput: one item per cycle while o_hd.ready is high; each stage holds its item only while the stage after it is
//   full and stalled, so bubbles close up under back-pressure.
// Reset clears the stage valid bits only; the datapath registers are not reset.
module vector_angle_degrees
    import vad_pkg::*;
#(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vad_pt_if.sink    i_pt,
    vad_hd_if.source  o_hd
);
    localparam int NV = CORDIC_STAGES + 3;
    localparam logic [HEADING_W:0] HEADING_LIM = (HEADING_W+1)'(32'd360 << ANGLE_FRAC_BITS);

    logic [NV-1:0]           r_valid;
    logic [NV-1:0]           n_valid;
    logic [NV-1:0]           w_en;

    logic signed [XY_W-1:0]  w_x   [CORDIC_STAGES+1];
    logic signed [XY_W-1:0]  w_y   [CORDIC_STAGES+1];
    logic signed [ACC_W-1:0] w_acc [CORDIC_STAGES+1];
    logic                    w_zero[CORDIC_STAGES+1];

    // a stage may load when it is empty or its contents move on
    always_comb begin
        w_en[NV-1] = !r_valid[NV-1] || o_hd.ready;
        for (int k = NV - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
        for (int k = 0; k < NV; k++) begin
            if (w_en[k]) begin
                n_valid[k] = (k == 0) ? i_pt.valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign i_pt.ready = w_en[0];
    assign o_hd.valid = r_valid[NV-1];

    vad_prep #(
        .COORD_BITS (COORD_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_en     (w_en[0]),
        .i_from_x (i_pt.from_x),
        .i_from_y (i_pt.from_y),
        .i_to_x   (i_pt.to_x),
        .i_to_y   (i_pt.to_y),
        .o_x      (w_x[0]),
        .o_y      (w_y[0]),
        .o_acc    (w_acc[0]),
        .o_zero   (w_zero[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        vad_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (w_en[g+1]),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_acc  (w_acc[g]),
            .i_zero (w_zero[g]),
            .o_x    (w_x[g+1]),
            .o_y    (w_y[g+1]),
            .o_acc  (w_acc[g+1]),
            .o_zero (w_zero[g+1])
        );
    end

    vad_finish #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_finish (
        .i_clk      (i_clk),
        .i_en_round (w_en[NV-2]),
        .i_en_out   (w_en[NV-1]),
        .i_acc      (w_acc[CORDIC_STAGES]),
        .i_zero     (w_zero[CORDIC_STAGES]),
        .o_heading  (o_hd.heading)
    );

    // a valid heading stays inside one turn; checked only when ANGLE_FRAC_BITS is 7 or less
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hd.valid |-> (ANGLE_FRAC_BITS > 7) || ({1'b0, o_hd.heading} < HEADING_LIM))
        else $error("heading outside one turn");

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> r_valid[0])
        else $error("accepted item lost at entry");

    // an empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[NV-1] |-> i_pt.ready)
        else $error("input stalled with empty output");
endmodule

// ----- tb/tb_vector_angle_degrees.sv -----
// Self-checking testbench for the vector angle pipeline: point pairs in, headings checked.
`timescale 1ns / 100ps

module tb_vector_angle_degrees;
    import vad_pkg::*;

    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int PIPE_LATENCY    = CORDIC_STAGES + 3;

    localparam int PRESCALE   = SCALE_TOP - COORD_BITS;
    localparam int ROUND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam longint FULL_TURN = longint'(360) <<< ANGLE_FRAC_BITS;
    localparam longint ACC_180   = longint'(180) <<< ACC_FRAC;
    localparam longint ACC_360   = longint'(360) <<< ACC_FRAC;

    localparam int RANDOM_ITEMS = 1800;
    localparam int STALL_AT     = 600;
    localparam int DRAIN_AT     = 1100;
    localparam int QUIET_AT     = 1600;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] tx;
        logic [15:0] ty;
        logic        typed;
        logic [15:0] heading;
    } t_pt_row;

    localparam int N_DIRECTED = 24;
    localparam t_pt_row DIRECTED [N_DIRECTED] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0},  // equal points at origin
        '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 16'd0},
        '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 16'd0},
        '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 1'b0, 16'd0},  // unit steps on each axis
        '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0, 16'd0},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, 16'd0},
        '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'd0},
        '{16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'd0},  // widest differences
        '{16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 1'b0, 16'd0},
        '{16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 1'b0, 16'd0},
        '{16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 1'b0, 16'd0},
        '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0, 16'd0},
        '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'd0},
        '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 16'd0},
        '{16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, 16'd0},
        '{16'h8000, 16'h0000, 16'h7FFF, 16'hFFFF, 1'b0, 16'd0},  // just below 360, wraps
        '{16'h8000, 16'h0001, 16'h7FFF, 16'h0000, 1'b0, 16'd0},
        '{16'h7FFF, 16'h0000, 16'h8000, 16'h0001, 1'b0, 16'd0},  // either side of 180
        '{16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b0, 16'd0},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0},
        '{16'h0000, 16'h0000, 16'h0001, 16'hFFFF, 1'b0, 16'd0},
        '{16'h1234, 16'hABCD, 16'h1234, 16'hABCD, 1'b1, 16'd0},
        '{16'h0000, 16'h0000, 16'h7FFF, 16'h0001, 1'b0, 16'd0},
        '{16'h0000, 16'h0000, 16'h0003, 16'h0004, 1'b0, 16'd0}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    vad_pt_if #(.COORD_BITS(COORD_BITS)) pt_ch ();
    vad_hd_if                            hd_ch ();

    vector_angle_degrees #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_STAGES   (CORDIC_STAGES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_hd    (hd_ch)
    );

    logic [15:0] heading_q [$];
    int          cycle_cnt        = 0;
    int          mismatch_cnt     = 0;
    int          headings_checked = 0;
    int          pairs_sent       = 0;
    bit          stall_req        = 1'b0;
    bit          quiet            = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Direction of B - A in 2^-ANGLE_FRAC_BITS degree, by fixed-length vectoring CORDIC.
    function automatic logic [15:0] heading_between(input logic signed [15:0] fx,
                                                    input logic signed [15:0] fy,
                                                    input logic signed [15:0] tx,
                                                    input logic signed [15:0] ty);
        longint dx, dy, x, y, xs, ys, acc, h;
        int     k;
        dx = longint'(tx) - longint'(fx);
        dy = longint'(ty) - longint'(fy);
        if (dx == 0 && dy == 0) begin
            return 16'd0;
        end
        x   = dx <<< PRESCALE;
        y   = dy <<< PRESCALE;
        acc = 0;
        // fold the left half-plane over so the rotations converge
        if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = ACC_180;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            k  = (i < TABLE_LEN) ? i : TABLE_LEN - 1;
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x   = x + ys;
                y   = y - xs;
                acc = acc + longint'(ATAN_TAB[k]);
            end else begin
                x   = x - ys;
                y   = y + xs;
                acc = acc - longint'(ATAN_TAB[k]);
            end
        end
        if (acc < 0) begin
            acc = acc + ACC_360;
        end
        if (acc < 0) begin
            acc = 0;
        end
        h = (acc + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
        while (h >= FULL_TURN) begin
            h = h - FULL_TURN;
        end
        return h[15:0];
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatch_cnt++;
        $display("mismatch at cycle %0d: %s, expected %0d, got %0d",
                 cycle_cnt, what, want, got);
    endtask

    // Offer one item and hold it until the handshake; valid stays high afterwards.
    task automatic offer_points(input logic [15:0] fx, input logic [15:0] fy,
                                input logic [15:0] tx, input logic [15:0] ty,
                                input logic typed, input logic [15:0] typed_heading);
        pt_ch.valid  <= 1'b1;
        pt_ch.from_x <= fx;
        pt_ch.from_y <= fy;
        pt_ch.to_x   <= tx;
        pt_ch.to_y   <= ty;
        @(posedge i_clk);
        while (!pt_ch.ready) begin
            @(posedge i_clk);
        end
        if (typed) begin
            heading_q.push_back(typed_heading);
        end else begin
            heading_q.push_back(heading_between(fx, fy, tx, ty));
        end
        pairs_sent++;
    endtask

    task automatic idle_sender(input int cycles);
        pt_ch.valid  <= 1'b0;
        pt_ch.from_x <= 16'($urandom());
        pt_ch.from_y <= 16'($urandom());
        pt_ch.to_x   <= 16'($urandom());
        pt_ch.to_y   <= 16'($urandom());
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [15:0] corner_coord();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic pick_points(output logic [15:0] fx, output logic [15:0] fy,
                               output logic [15:0] tx, output logic [15:0] ty);
        fx = 16'($urandom());
        fy = 16'($urandom());
        tx = 16'($urandom());
        ty = 16'($urandom());
        case ($urandom_range(0, 9))
            4: begin
                tx = fx;
                ty = fy;
            end
            5: begin
                tx = fx + 16'($urandom_range(0, 8)) - 16'd4;
                ty = fy + 16'($urandom_range(0, 8)) - 16'd4;
            end
            6: begin
                if ($urandom_range(0, 1)) tx = fx;
                else                      ty = fy;
            end
            7: begin
                fx = corner_coord();
                fy = corner_coord();
                tx = corner_coord();
                ty = corner_coord();
            end
            8: begin
                tx = fx + 16'($urandom_range(0, 255)) - 16'd128;
                ty = fy + 16'($urandom_range(0, 255)) - 16'd128;
            end
            9: begin
                // hug an axis: a tiny offset on one side, anything on the other
                if ($urandom_range(0, 1)) ty = fy + 16'($urandom_range(0, 4)) - 16'd2;
                else                      tx = fx + 16'($urandom_range(0, 4)) - 16'd2;
            end
            default: ;
        endcase
    endtask

    // Stimulus, pressure points and the end of the run.
    initial begin : sender
        logic [15:0] fx, fy, tx, ty;
        pt_ch.valid  = 1'b0;
        pt_ch.from_x = '0;
        pt_ch.from_y = '0;
        pt_ch.to_x   = '0;
        pt_ch.to_y   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_points(DIRECTED[r].fx, DIRECTED[r].fy, DIRECTED[r].tx, DIRECTED[r].ty,
                         DIRECTED[r].typed, DIRECTED[r].heading);
            if (r % 5 == 4) begin
                idle_sender($urandom_range(1, 7));
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == STALL_AT) begin
                stall_req = 1'b1;
            end
            if (n == DRAIN_AT) begin
                // pause until the pipe has emptied
                pt_ch.valid <= 1'b0;
                while (heading_q.size() != 0) begin
                    @(posedge i_clk);
                end
                @(posedge i_clk);
            end
            if (n == QUIET_AT) begin
                quiet = 1'b1;
            end
            pick_points(fx, fy, tx, ty);
            offer_points(fx, fy, tx, ty, 1'b0, 16'd0);
            if (!quiet && $urandom_range(0, 7) == 0) begin
                idle_sender($urandom_range(1, 7));
            end
        end

        pt_ch.valid <= 1'b0;
        while (heading_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);

        $display("covered %0d point pairs (%0d from the directed table) and compared %0d headings",
                 pairs_sent, N_DIRECTED, headings_checked);
        $display("with random gaps on both sides, one %0d-cycle output hold-off and one full drain",
                 LONG_HOLD);
        if (mismatch_cnt == 0) begin
            $display("PASS vector_angle_degrees");
        end else begin
            $display("FAIL vector_angle_degrees");
        end
        $finish;
    end

    // Output side back-pressure.
    initial begin : receiver
        int hold_left, idle_left, free_left;
        hold_left   = 0;
        idle_left   = 0;
        free_left   = 0;
        hd_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                hd_ch.ready <= 1'b0;
            end else if (stall_req) begin
                // long hold-off so the pipe fills and stalls the input
                stall_req = 1'b0;
                hold_left = LONG_HOLD - 1;
                hd_ch.ready <= 1'b0;
            end else if (quiet) begin
                hd_ch.ready <= 1'b1;
            end else if (idle_left > 0) begin
                idle_left--;
                hd_ch.ready <= 1'b0;
            end else if (free_left > 0) begin
                free_left--;
                hd_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 19) == 0) begin
                free_left = $urandom_range(20, 80);
                hd_ch.ready <= 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 7) - 1;
                hd_ch.ready <= 1'b0;
            end else begin
                hd_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && hd_ch.valid && hd_ch.ready) begin
            if (heading_q.size() == 0) begin
                note_mismatch("heading with nothing pending", 16'd0, hd_ch.heading);
            end else begin
                headings_checked++;
                if (hd_ch.heading !== heading_q[0]) begin
                    note_mismatch("heading", heading_q[0], hd_ch.heading);
                end
                void'(heading_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d headings pending",
                     cycle_cnt, heading_q.size());
            $display("FAIL vector_angle_degrees");
            $finish;
        end
    end

endmodule
